// ===== hw/rtl/swct_pkg.sv =====
// ----------------------------------------------------------------------------
// swct_pkg: shared types and codes for the segment wall crossing tester
// Holds the function codes of an input item and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package swct_pkg;

  // Width of the function code of an input item.
  localparam int FUNC_W = 2;

  // Function codes. The fourth code is unused and leaves the table alone.
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // latch the input payload of an accepted transaction
    logic apply;     // carry out the latched function, start a scan if a query
    logic out_load;  // load the result into the output register
  } swct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;   // latched function is a query
    logic scan_busy;  // table walk or its pipeline still in flight
  } swct_stat_t;

endpackage

// ===== hw/rtl/swct_if.sv =====
// ----------------------------------------------------------------------------
// swct_if: valid/ready channels of the segment wall crossing tester
// One interface for the input items and one for the result items.
// ----------------------------------------------------------------------------

// Input channel: one function code and one segment per transaction.
interface swct_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (
    output valid, func, start_x, start_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, func, start_x, start_y, end_x, end_y,
    output ready
  );
endinterface

// Result channel: one result per input transaction.
interface swct_out_if #(
  parameter int CNT_W = 7
) ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [CNT_W-1:0] wall_count;
  logic             full_error;

  modport source (
    output valid, hit, wall_count, full_error,
    input  ready
  );
  modport sink (
    input  valid, hit, wall_count, full_error,
    output ready
  );
endinterface

// ===== hw/rtl/swct_ctrl.sv =====
// ----------------------------------------------------------------------------
// swct_ctrl: controller of the segment wall crossing tester
// Sequences accept, execute, table walk and result load, and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module swct_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  swct_pkg::swct_stat_t   stat,
  output swct_pkg::swct_cmd_t    cmd
);
  import swct_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd.take     = 1'b0;
    cmd.apply    = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // No transaction is taken while reset is held.
        in_ready = rst_n;
        if (rst_n && in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.apply = 1'b1;
        state_nxt = stat.is_query ? ST_SCAN : ST_RESULT;
      end
      ST_SCAN: begin
        if (!stat.scan_busy) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The output register is full until its transaction completes.
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/swct_dp.sv =====
// ----------------------------------------------------------------------------
// swct_dp: datapath of the segment wall crossing tester
// Holds the wall table memory and the wall count, and walks the table one
// wall per cycle through a pipeline of differences, cross products and
// range checks.
// ----------------------------------------------------------------------------
module swct_dp #(
  parameter int MAX_WALLS  = 64,
  parameter int COORD_BITS = 16,
  parameter int CNT_W      = 7,
  parameter int IDX_W      = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  swct_pkg::swct_cmd_t          cmd,
  output swct_pkg::swct_stat_t         stat,
  input  logic [swct_pkg::FUNC_W-1:0]  in_func,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  output logic                         out_hit,
  output logic [CNT_W-1:0]             out_wall_count,
  output logic                         out_full_error
);
  import swct_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = CB + 1;      // coordinate difference
  localparam int PW = 2 * DW;      // cross product term
  localparam int NW = PW + 1;      // numerator or denominator
  localparam int EW = 4 * CB;      // one table entry

  // Latched input item.
  logic [FUNC_W-1:0]    func_r;
  logic signed [CB-1:0] sx_r, sy_r, ex_r, ey_r;

  // Path direction, fixed for one query.
  logic signed [DW-1:0] pdx_r, pdy_r;

  // Table state.
  logic [EW-1:0]    mem [MAX_WALLS];
  logic [CNT_W-1:0] count_r;
  logic             err_r;
  logic             full;

  // Walk and pipeline.
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 issuing_r;
  logic [EW-1:0]        rd_data_r;
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic signed [DW-1:0] wdx_r, wdy_r, ox_r, oy_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [NW-1:0] den_r, na_r, nb_r;
  logic                 hit_acc_r;
  logic                 wall_hit;
  logic signed [CB-1:0] wx1, wy1, wx2, wy2;

  // Output register payload.
  logic             out_hit_r, out_err_r;
  logic [CNT_W-1:0] out_count_r;

  assign full = (count_r == CNT_W'(MAX_WALLS));

  // Input latch and path direction.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func_r <= in_func;
      sx_r   <= in_start_x;
      sy_r   <= in_start_y;
      ex_r   <= in_end_x;
      ey_r   <= in_end_y;
    end
    if (cmd.apply) begin
      pdx_r <= {ex_r[CB-1], ex_r} - {sx_r[CB-1], sx_r};
      pdy_r <= {ey_r[CB-1], ey_r} - {sy_r[CB-1], sy_r};
    end
  end

  // Wall table memory: written by an add, read once per cycle by the walk.
  always_ff @(posedge clk) begin
    if (cmd.apply && (func_r == FUNC_ADD) && !full) begin
      mem[count_r[IDX_W-1:0]] <= {sx_r, sy_r, ex_r, ey_r};
    end
    rd_data_r <= mem[rd_idx_r];
  end

  // Wall count and full flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.apply) begin
      if (func_r == FUNC_CLEAR) begin
        count_r <= '0;
      end else if ((func_r == FUNC_ADD) && !full) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      err_r <= (func_r == FUNC_ADD) && full;
    end
  end

  // Read address walk over the stored walls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
    end else if (cmd.apply) begin
      issuing_r <= (func_r == FUNC_QUERY) && (count_r != '0);
    end else if (issuing_r && (CNT_W'(rd_idx_r) + CNT_W'(1) == count_r)) begin
      issuing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rd_idx_r <= '0;
    end else if (issuing_r) begin
      rd_idx_r <= rd_idx_r + IDX_W'(1);
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issuing_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage one: wall direction and offset of the path start from the wall.
  assign {wx1, wy1, wx2, wy2} = rd_data_r;

  always_ff @(posedge clk) begin
    wdx_r <= {wx2[CB-1], wx2} - {wx1[CB-1], wx1};
    wdy_r <= {wy2[CB-1], wy2} - {wy1[CB-1], wy1};
    ox_r  <= {sx_r[CB-1], sx_r} - {wx1[CB-1], wx1};
    oy_r  <= {sy_r[CB-1], sy_r} - {wy1[CB-1], wy1};
  end

  // Stage two: the six cross product terms, one multiplier each.
  always_ff @(posedge clk) begin
    p0_r <= wdy_r * pdx_r;
    p1_r <= wdx_r * pdy_r;
    p2_r <= wdx_r * oy_r;
    p3_r <= wdy_r * ox_r;
    p4_r <= pdx_r * oy_r;
    p5_r <= pdy_r * ox_r;
  end

  // Stage three: denominator and the two numerators.
  always_ff @(posedge clk) begin
    den_r <= {p0_r[PW-1], p0_r} - {p1_r[PW-1], p1_r};
    na_r  <= {p2_r[PW-1], p2_r} - {p3_r[PW-1], p3_r};
    nb_r  <= {p4_r[PW-1], p4_r} - {p5_r[PW-1], p5_r};
  end

  // Stage four: both parameters lie in the closed unit interval, which is
  // checked without division by comparing each numerator to the denominator.
  always_comb begin
    if (den_r == '0) begin
      wall_hit = 1'b0;
    end else if (!den_r[NW-1]) begin
      wall_hit = !na_r[NW-1] && (na_r <= den_r) && !nb_r[NW-1] && (nb_r <= den_r);
    end else begin
      wall_hit = ((na_r == '0) || na_r[NW-1]) && (na_r >= den_r) &&
                 ((nb_r == '0) || nb_r[NW-1]) && (nb_r >= den_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      hit_acc_r <= 1'b0;
    end else if (v4_r && wall_hit) begin
      hit_acc_r <= 1'b1;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_hit_r   <= hit_acc_r;
      out_err_r   <= err_r;
      out_count_r <= count_r;
    end
  end

  assign out_hit        = out_hit_r;
  assign out_full_error = out_err_r;
  assign out_wall_count = out_count_r;

  assign stat.is_query  = (func_r == FUNC_QUERY);
  assign stat.scan_busy = issuing_r || v1_r || v2_r || v3_r || v4_r;

endmodule

// ===== hw/rtl/segment_wall_crossing_test_top.sv =====
// ----------------------------------------------------------------------------
// segment_wall_crossing_test_top: wall table with segment crossing queries
// Clears the table, adds a wall or tests a movement segment against all
// stored walls, and returns one result per input transaction.
//
//   Channel | Role   | Transaction payload
//   --------+--------+---------------------------------------------------
//   in_ch   | sink   | func, start_x, start_y, end_x, end_y
//   out_ch  | source | hit, wall_count, full_error
//
// A clear, an add or an unused code passes from acceptance through the
// execute state to a loaded result. A query walks all N stored walls (none
// on an empty table) through the table memory's single read port, which
// delivers one wall a cycle into a four-stage pipeline.
// The block takes one item at a time and accepts the next one while the
// previous result still waits in the output register. Reset empties the
// table at once; the table memory needs no clearing pass.
// ----------------------------------------------------------------------------
module segment_wall_crossing_test_top #(
  parameter int MAX_WALLS  = 64,
  parameter int COORD_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  swct_in_if.sink    in_ch,
  swct_out_if.source out_ch
);
  import swct_pkg::*;

  localparam int CNT_W = $clog2(MAX_WALLS + 1);
  localparam int IDX_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

  swct_cmd_t  cmd;
  swct_stat_t stat;

  // Controller.
  swct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath.
  swct_dp #(
    .MAX_WALLS  (MAX_WALLS),
    .COORD_BITS (COORD_BITS),
    .CNT_W      (CNT_W),
    .IDX_W      (IDX_W)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_func        (in_ch.func),
    .in_start_x     (in_ch.start_x),
    .in_start_y     (in_ch.start_y),
    .in_end_x       (in_ch.end_x),
    .in_end_y       (in_ch.end_y),
    .out_hit        (out_ch.hit),
    .out_wall_count (out_ch.wall_count),
    .out_full_error (out_ch.full_error)
  );

  // After an accepted transaction the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted twice in consecutive cycles");

  // A result is only loaded into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("pending result overwritten");

  // The reported count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.wall_count <= CNT_W'(MAX_WALLS)))
    else $error("wall count beyond table size");

  // A dropped add never reports a hit.
  a_hit_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.full_error))
    else $error("hit and full error reported together");

endmodule

// ===== tb/tb_segment_wall_crossing_test_top.sv =====
// ----------------------------------------------------------------------------
// tb_segment_wall_crossing_test_top: self-checking bench for the wall tester
// Drives clear, add, query and unused-code transactions into the block and
// predicts each result with an exact integer crossing test over a private
// copy of the wall table. Results are compared field by field in order,
// while both channels stall at random in the first two of three pressure phases.
// ----------------------------------------------------------------------------
module tb_segment_wall_crossing_test_top;
  import swct_pkg::*;

  localparam int MAX_WALLS    = 64;
  localparam int COORD_BITS   = 16;
  localparam int CNT_W        = 7;
  localparam int RANDOM_ITEMS = 650;
  localparam int DRAIN_CYCLES = 100;
  localparam int RUN_LIMIT    = 1000000;
  localparam int METRE        = 256;

  // The fourth function code is undefined and must leave the table alone.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Keeps the expected wall table and the results still owed by the block.
  class wall_crossing_scoreboard;
    typedef struct {
      longint x1, y1, x2, y2;
    } segment_t;

    typedef struct {
      logic             hit;
      logic [CNT_W-1:0] wall_count;
      logic             full_error;
    } outcome_t;

    segment_t    wall_table[MAX_WALLS];
    int unsigned wall_total;
    outcome_t    owed_outcomes[$];
    int unsigned errors;

    function new();
      wall_total = 0;
      errors     = 0;
    endfunction

    // True when 0 <= n/d <= 1 for a nonzero d, ends inclusive.
    function bit on_segment(longint n, longint d);
      if (d > 0) return (n >= 0) && (n <= d);
      return (n <= 0) && (n >= d);
    endfunction

    // Parametric line test; parallel or degenerate pairs never meet.
    function bit paths_cross(segment_t w, segment_t p);
      longint wdx, wdy, pdx, pdy, ox, oy, den, na, nb;
      wdx = w.x2 - w.x1;
      wdy = w.y2 - w.y1;
      pdx = p.x2 - p.x1;
      pdy = p.y2 - p.y1;
      ox  = p.x1 - w.x1;
      oy  = p.y1 - w.y1;
      den = wdy * pdx - wdx * pdy;
      if (den == 0) return 1'b0;
      na = wdx * oy - wdy * ox;
      nb = pdx * oy - pdy * ox;
      return on_segment(na, den) && on_segment(nb, den);
    endfunction

    // Applies one accepted transaction and queues the result it must cause.
    function void note_input(logic [FUNC_W-1:0] func, coord_t sx, coord_t sy,
                             coord_t ex, coord_t ey);
      segment_t seg;
      outcome_t res;
      seg.x1 = sx;
      seg.y1 = sy;
      seg.x2 = ex;
      seg.y2 = ey;
      res.hit        = 1'b0;
      res.full_error = 1'b0;
      case (func)
        FUNC_CLEAR: begin
          wall_total = 0;
        end
        FUNC_ADD: begin
          if (wall_total < MAX_WALLS) begin
            wall_table[wall_total] = seg;
            wall_total++;
          end else begin
            res.full_error = 1'b1;
          end
        end
        FUNC_QUERY: begin
          for (int i = 0; i < wall_total; i++) begin
            if (paths_cross(wall_table[i], seg)) begin
              res.hit = 1'b1;
              break;
            end
          end
        end
        default: ;
      endcase
      res.wall_count = CNT_W'(wall_total);
      owed_outcomes = {owed_outcomes, res};
    endfunction

    // Compares one result transaction with the oldest owed result.
    function void check_result(logic hit, logic [CNT_W-1:0] wall_count,
                               logic full_error);
      outcome_t want;
      if (owed_outcomes.size() == 0) begin
        $display("%0t: unexpected result hit=%0b wall_count=%0d full_error=%0b",
                 $time, hit, wall_count, full_error);
        errors++;
        return;
      end
      want = owed_outcomes.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit mismatch, expected %0b, actual %0b",
                 $time, want.hit, hit);
        errors++;
      end
      if (wall_count !== want.wall_count) begin
        $display("%0t: wall_count mismatch, expected %0d, actual %0d",
                 $time, want.wall_count, wall_count);
        errors++;
      end
      if (full_error !== want.full_error) begin
        $display("%0t: full_error mismatch, expected %0b, actual %0b",
                 $time, want.full_error, full_error);
        errors++;
      end
    endfunction

    function int owed();
      return owed_outcomes.size();
    endfunction
  endclass

  bit   clk = 1'b0;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;
  int unsigned counted_items = 0;

  wall_crossing_scoreboard wall_sb = new();

  swct_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
  swct_out_if #(.CNT_W(CNT_W))           out_ch ();

  segment_wall_crossing_test_top #(
    .MAX_WALLS (MAX_WALLS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // Presents one transaction, with random idle cycles ahead of it.
  task automatic send_item(logic [FUNC_W-1:0] func, coord_t sx, coord_t sy,
                           coord_t ex, coord_t ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= func;
    in_ch.start_x <= sx;
    in_ch.start_y <= sy;
    in_ch.end_x   <= ex;
    in_ch.end_y   <= ey;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    wall_sb.note_input(func, sx, sy, ex, ey);
    if (func != FUNC_UNUSED) counted_items++;
  endtask

  // Mostly full-range or one-metre-grid values, with the odd extreme mixed in.
  function automatic coord_t pick_coord(bit on_grid);
    coord_t value;
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(3))
        0:       value = 16'sh8000;
        1:       value = 16'sh7fff;
        2:       value = '0;
        default: value = '1;
      endcase
    end else if (on_grid) begin
      value = coord_t'((int'($urandom_range(8)) - 4) * METRE);
    end else begin
      value = coord_t'($urandom);
    end
    return value;
  endfunction

  task automatic send_segment(logic [FUNC_W-1:0] func, bit on_grid);
    send_item(func, pick_coord(on_grid), pick_coord(on_grid),
              pick_coord(on_grid), pick_coord(on_grid));
  endtask

  // Hand-picked geometry: crossings, endpoint touches and the no-hit cases.
  task automatic run_directed();
    send_item(FUNC_QUERY, -METRE, -METRE, METRE, METRE);       // empty table
    send_item(FUNC_ADD, 0, 0, 4 * METRE, 0);
    send_item(FUNC_QUERY, 2 * METRE, -2 * METRE, 2 * METRE, 2 * METRE);
    send_item(FUNC_QUERY, 4 * METRE, 0, 4 * METRE, 2 * METRE);  // wall end
    send_item(FUNC_QUERY, 2 * METRE, -METRE, 2 * METRE, 0);     // path end
    send_item(FUNC_QUERY, 0, METRE, 4 * METRE, METRE);          // parallel
    send_item(FUNC_QUERY, 2 * METRE, 0, 8 * METRE, 0);          // collinear
    send_item(FUNC_QUERY, 2 * METRE, 0, 2 * METRE, 0);          // point path
    send_item(FUNC_QUERY, 2 * METRE, METRE, 2 * METRE, 4 * METRE);
    send_item(FUNC_ADD, -4 * METRE, -4 * METRE, -4 * METRE, -4 * METRE);
    send_item(FUNC_QUERY, -8 * METRE, -4 * METRE, 0, -4 * METRE);
    send_item(FUNC_ADD, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_item(FUNC_QUERY, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(FUNC_UNUSED, '1, '1, '1, '1);
    send_item(FUNC_ADD, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
    send_item(FUNC_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_item(FUNC_QUERY, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send_item(FUNC_CLEAR, '1, '1, '1, '1);
    send_item(FUNC_QUERY, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_item(FUNC_UNUSED, '0, '0, '0, '0);
    send_item(FUNC_ADD, 16'sh8000, 0, 16'sh7fff, 0);
    send_item(FUNC_QUERY, 0, 16'sh8000, 0, 16'sh7fff);
  endtask

  // One well-formed sequence: maybe clear, a run of adds, then queries.
  task automatic run_episode(bit force_fill);
    bit          on_grid;
    int unsigned adds;
    int unsigned queries;
    on_grid = $urandom_range(1);
    if (force_fill || $urandom_range(7) == 0) adds = MAX_WALLS + $urandom_range(1, 4);
    else adds = $urandom_range(12);
    if ($urandom_range(4) != 0) send_segment(FUNC_CLEAR, on_grid);
    repeat (adds) begin
      if ($urandom_range(19) == 0) send_segment(FUNC_UNUSED, on_grid);
      if ($urandom_range(9) == 0) send_segment(FUNC_QUERY, on_grid);
      send_segment(FUNC_ADD, on_grid);
    end
    queries = $urandom_range(2, 10);
    repeat (queries) begin
      if ($urandom_range(19) == 0) send_segment(FUNC_UNUSED, on_grid);
      send_segment(FUNC_QUERY, on_grid);
    end
  endtask

  // Random sequences across the three pressure phases.
  task automatic run_random();
    int unsigned base;
    int unsigned done;
    bit          first_pass;
    base       = counted_items;
    first_pass = 1'b1;
    while (counted_items < base + RANDOM_ITEMS) begin
      done = counted_items - base;
      if (done >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (done >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 63;
        recv_idle_pct = 34;
      end
      run_episode(first_pass);
      first_pass = 1'b0;
    end
  endtask

  // Stimulus, drain and the final verdict.
  initial begin
    send_idle_pct = 34;
    recv_idle_pct = 63;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FUNC_CLEAR;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.end_x   <= '0;
    in_ch.end_y   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_ch.valid <= 1'b0;
    while (wall_sb.owed() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (wall_sb.errors == 0 && wall_sb.owed() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: random back-pressure, every transaction checked.
  initial begin
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        wall_sb.check_result(out_ch.hit, out_ch.wall_count, out_ch.full_error);
      end
    end
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
